/* hdl/lcdws_pkg.sv */
// lcdws_pkg: types, command codes, display byte constants and the power-up
// segment table shared by the lcd 4-bit write sequencer modules
// no dependencies
`default_nettype none

package lcdws_pkg;

   // request codes
   localparam logic [3:0] CMD_INIT        = 4'd0;
   localparam logic [3:0] CMD_CHAR        = 4'd1;
   localparam logic [3:0] CMD_CLEAR       = 4'd2;
   localparam logic [3:0] CMD_HOME        = 4'd3;
   localparam logic [3:0] CMD_DISP_RIGHT  = 4'd4;
   localparam logic [3:0] CMD_DISP_LEFT   = 4'd5;
   localparam logic [3:0] CMD_CURS_RIGHT  = 4'd6;
   localparam logic [3:0] CMD_CURS_LEFT   = 4'd7;
   localparam logic [3:0] CMD_MODE        = 4'd8;
   localparam logic [3:0] CMD_POSITION    = 4'd9;

   // display mode codes
   localparam logic [2:0] MODE_PLAIN  = 3'd0;
   localparam logic [2:0] MODE_BLINK  = 3'd1;
   localparam logic [2:0] MODE_CURSOR = 3'd2;

   // controller instruction bytes
   localparam logic [7:0] BYTE_FUNC_SET    = 8'h28;
   localparam logic [7:0] BYTE_DISP_PLAIN  = 8'h0c;
   localparam logic [7:0] BYTE_DISP_BLINK  = 8'h0d;
   localparam logic [7:0] BYTE_DISP_CURSOR = 8'h0e;
   localparam logic [7:0] BYTE_CLEAR       = 8'h01;
   localparam logic [7:0] BYTE_HOME        = 8'h02;
   localparam logic [7:0] BYTE_DISP_RIGHT  = 8'h1c;
   localparam logic [7:0] BYTE_DISP_LEFT   = 8'h18;
   localparam logic [7:0] BYTE_CURS_RIGHT  = 8'h14;
   localparam logic [7:0] BYTE_CURS_LEFT   = 8'h10;
   localparam logic [7:0] BYTE_SET_DDRAM   = 8'h80;
   localparam logic [7:0] ROW1_OFFSET      = 8'h40;
   localparam logic [7:0] CHAR_NEWLINE     = 8'h0a;
   localparam logic [7:0] CHAR_RETURN      = 8'h0d;

   // register indexes
   localparam logic CSR_PULSE  = 1'b0;
   localparam logic CSR_SETTLE = 1'b1;

   localparam logic [15:0] PULSE_RESET  = 16'd5;
   localparam logic [15:0] SETTLE_RESET = 16'd100;

   localparam logic [4:0] INIT_SEGS = 5'd29;

   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] char_code;
      logic [2:0] display_mode;
      logic       row;
      logic [5:0] column;
   } req_type;

   typedef struct packed {
      logic        reg_select;
      logic        enable;
      logic [3:0]  data_nibble;
      logic [15:0] hold_time;
      logic        accepted;
      logic        last;
   } rsp_type;

   // where a segment's hold time comes from
   typedef enum logic [3:0] {
      HOLD_NONE,
      HOLD_PULSE,
      HOLD_SETTLE,
      HOLD_T20000,
      HOLD_T5000,
      HOLD_T3000,
      HOLD_T110,
      HOLD_T100,
      HOLD_T50
   } hold_sel_type;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_BYTES,
      JOB_REJECT
   } job_kind_type;

   // classified request as it sits in the queue
   typedef struct packed {
      job_kind_type kind;
      logic         rs;
      logic         two_bytes;   // carriage return goes out before the byte
      logic [7:0]   data;
      hold_sel_type tail;
   } job_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } back_state_type;

   typedef struct packed {
      logic         enable;
      logic [3:0]   nibble;
      hold_sel_type hold;
   } init_seg_type;

   // power-up sequence, one entry per segment
   function automatic init_seg_type init_seg(input logic [4:0] idx);
      init_seg_type s;
      s = '{enable: 1'b0, nibble: 4'h0, hold: HOLD_NONE};
      unique case (idx)
         5'd0:  s = '{1'b0, 4'h0, HOLD_T20000};
         5'd1:  s = '{1'b1, 4'h3, HOLD_PULSE};
         5'd2:  s = '{1'b0, 4'h3, HOLD_SETTLE};
         5'd3:  s = '{1'b0, 4'h3, HOLD_T5000};
         5'd4:  s = '{1'b1, 4'h3, HOLD_PULSE};
         5'd5:  s = '{1'b0, 4'h3, HOLD_SETTLE};
         5'd6:  s = '{1'b0, 4'h3, HOLD_T110};
         5'd7:  s = '{1'b1, 4'h3, HOLD_PULSE};
         5'd8:  s = '{1'b0, 4'h3, HOLD_SETTLE};
         5'd9:  s = '{1'b0, 4'h3, HOLD_T3000};
         5'd10: s = '{1'b1, 4'h2, HOLD_PULSE};
         5'd11: s = '{1'b0, 4'h2, HOLD_SETTLE};
         5'd12: s = '{1'b0, 4'h2, HOLD_T3000};
         5'd13: s = '{1'b1, BYTE_FUNC_SET[7:4], HOLD_PULSE};
         5'd14: s = '{1'b0, BYTE_FUNC_SET[7:4], HOLD_SETTLE};
         5'd15: s = '{1'b1, BYTE_FUNC_SET[3:0], HOLD_PULSE};
         5'd16: s = '{1'b0, BYTE_FUNC_SET[3:0], HOLD_SETTLE};
         5'd17: s = '{1'b0, BYTE_FUNC_SET[3:0], HOLD_T3000};
         5'd18: s = '{1'b1, BYTE_DISP_PLAIN[7:4], HOLD_PULSE};
         5'd19: s = '{1'b0, BYTE_DISP_PLAIN[7:4], HOLD_SETTLE};
         5'd20: s = '{1'b1, BYTE_DISP_PLAIN[3:0], HOLD_PULSE};
         5'd21: s = '{1'b0, BYTE_DISP_PLAIN[3:0], HOLD_SETTLE};
         5'd22: s = '{1'b0, BYTE_DISP_PLAIN[3:0], HOLD_T100};
         5'd23: s = '{1'b0, BYTE_DISP_PLAIN[3:0], HOLD_T3000};
         5'd24: s = '{1'b1, BYTE_CLEAR[7:4], HOLD_PULSE};
         5'd25: s = '{1'b0, BYTE_CLEAR[7:4], HOLD_SETTLE};
         5'd26: s = '{1'b1, BYTE_CLEAR[3:0], HOLD_PULSE};
         5'd27: s = '{1'b0, BYTE_CLEAR[3:0], HOLD_SETTLE};
         5'd28: s = '{1'b0, BYTE_CLEAR[3:0], HOLD_T3000};
         default: s = '{1'b0, 4'h0, HOLD_NONE};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

/* hdl/lcdws_front.sv */
// lcdws_front: request intake and decode into a queue job
// depends on lcdws_pkg
`default_nettype none

module lcdws_front (
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lcdws_pkg::req_type req_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output lcdws_pkg::job_type     q_job
);

   assign req_ready = ~q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      q_job.kind      = lcdws_pkg::JOB_BYTES;
      q_job.rs        = 1'b0;
      q_job.two_bytes = 1'b0;
      q_job.data      = 8'h00;
      q_job.tail      = lcdws_pkg::HOLD_NONE;
      unique case (req_data.cmd)
         lcdws_pkg::CMD_INIT: begin
            q_job.kind = lcdws_pkg::JOB_INIT;
         end
         lcdws_pkg::CMD_CHAR: begin
            q_job.rs        = 1'b1;
            q_job.data      = req_data.char_code;
            q_job.two_bytes = (req_data.char_code == lcdws_pkg::CHAR_NEWLINE);
         end
         lcdws_pkg::CMD_CLEAR: begin
            q_job.data = lcdws_pkg::BYTE_CLEAR;
            q_job.tail = lcdws_pkg::HOLD_T5000;
         end
         lcdws_pkg::CMD_HOME: begin
            q_job.data = lcdws_pkg::BYTE_HOME;
            q_job.tail = lcdws_pkg::HOLD_T5000;
         end
         lcdws_pkg::CMD_DISP_RIGHT: begin
            q_job.data = lcdws_pkg::BYTE_DISP_RIGHT;
            q_job.tail = lcdws_pkg::HOLD_T100;
         end
         lcdws_pkg::CMD_DISP_LEFT: begin
            q_job.data = lcdws_pkg::BYTE_DISP_LEFT;
            q_job.tail = lcdws_pkg::HOLD_T100;
         end
         lcdws_pkg::CMD_CURS_RIGHT: begin
            q_job.data = lcdws_pkg::BYTE_CURS_RIGHT;
            q_job.tail = lcdws_pkg::HOLD_T100;
         end
         lcdws_pkg::CMD_CURS_LEFT: begin
            q_job.data = lcdws_pkg::BYTE_CURS_LEFT;
            q_job.tail = lcdws_pkg::HOLD_T100;
         end
         lcdws_pkg::CMD_MODE: begin
            q_job.tail = lcdws_pkg::HOLD_T100;
            unique case (req_data.display_mode)
               lcdws_pkg::MODE_PLAIN:  q_job.data = lcdws_pkg::BYTE_DISP_PLAIN;
               lcdws_pkg::MODE_BLINK:  q_job.data = lcdws_pkg::BYTE_DISP_BLINK;
               lcdws_pkg::MODE_CURSOR: q_job.data = lcdws_pkg::BYTE_DISP_CURSOR;
               default:                q_job.kind = lcdws_pkg::JOB_REJECT;
            endcase
         end
         lcdws_pkg::CMD_POSITION: begin
            // row offset plus column never carries into bit 7
            q_job.data = lcdws_pkg::BYTE_SET_DDRAM
                       | (req_data.row ? lcdws_pkg::ROW1_OFFSET : 8'h00)
                       | {2'b00, req_data.column};
            q_job.tail = lcdws_pkg::HOLD_T50;
         end
         default: begin
            q_job.kind = lcdws_pkg::JOB_REJECT;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/lcdws_queue.sv */
// lcdws_queue: small job fifo between decode and the segment sequencer
// depends on lcdws_pkg
`default_nettype none

module lcdws_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lcdws_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output lcdws_pkg::job_type     pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcdws_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue over depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("job queue lost a push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> rd_ptr_ff == wr_ptr_ff)
      else $error("job queue pointers disagree when empty");

endmodule

`default_nettype wire

/* hdl/lcdws_back.sv */
// lcdws_back: walks one job into pin segments, one beat per cycle unless rsp_ready
// stalls it, through a registered result stage; depends on lcdws_pkg
`default_nettype none

module lcdws_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        pulse_time,
   input  wire logic [15:0]        settle_time,
   input  wire logic               q_valid,
   input  wire lcdws_pkg::job_type q_job,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lcdws_pkg::rsp_type      rsp_data
);

   lcdws_pkg::back_state_type state_ff, state_in;
   lcdws_pkg::job_type        job_ff, job_in;
   logic [4:0]                idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lcdws_pkg::rsp_type        rsp_ff, rsp_in;

   logic                      advance;
   logic                      emit;
   logic [4:0]                byte_segs;
   logic [4:0]                seg_total;
   logic                      seg_last;
   logic [7:0]                cur_byte;
   lcdws_pkg::init_seg_type   iseg;
   lcdws_pkg::hold_sel_type   hsel;
   lcdws_pkg::rsp_type        seg;

   assign advance = ~rsp_valid_ff | rsp_ready;

   // segment count of the current job
   assign byte_segs = job_ff.two_bytes ? 5'd8 : 5'd4;
   always_comb begin
      case (job_ff.kind)
         lcdws_pkg::JOB_INIT:   seg_total = lcdws_pkg::INIT_SEGS;
         lcdws_pkg::JOB_REJECT: seg_total = 5'd1;
         default: seg_total = byte_segs
                            + {4'd0, job_ff.tail != lcdws_pkg::HOLD_NONE};
      endcase
   end
   assign seg_last = (idx_ff == seg_total - 5'd1);

   // segment at idx_ff
   assign iseg     = lcdws_pkg::init_seg(idx_ff);
   assign cur_byte = (job_ff.two_bytes && !idx_ff[2]) ? lcdws_pkg::CHAR_RETURN
                                                       : job_ff.data;
   always_comb begin
      seg  = '0;
      hsel = lcdws_pkg::HOLD_NONE;
      case (job_ff.kind)
         lcdws_pkg::JOB_INIT: begin
            seg.enable      = iseg.enable;
            seg.data_nibble = iseg.nibble;
            seg.accepted    = 1'b1;
            hsel            = iseg.hold;
         end
         lcdws_pkg::JOB_BYTES: begin
            seg.reg_select = job_ff.rs;
            seg.accepted   = 1'b1;
            if (idx_ff == byte_segs) begin
               // trailing wait keeps the low nibble of the last byte
               seg.data_nibble = job_ff.data[3:0];
               hsel            = job_ff.tail;
            end else begin
               seg.enable      = ~idx_ff[0];
               seg.data_nibble = idx_ff[1] ? cur_byte[3:0] : cur_byte[7:4];
               hsel            = idx_ff[0] ? lcdws_pkg::HOLD_SETTLE
                                           : lcdws_pkg::HOLD_PULSE;
            end
         end
         default: begin
            seg.accepted = 1'b0;
         end
      endcase
      case (hsel)
         lcdws_pkg::HOLD_PULSE:  seg.hold_time = pulse_time;
         lcdws_pkg::HOLD_SETTLE: seg.hold_time = settle_time;
         lcdws_pkg::HOLD_T20000: seg.hold_time = 16'd20000;
         lcdws_pkg::HOLD_T5000:  seg.hold_time = 16'd5000;
         lcdws_pkg::HOLD_T3000:  seg.hold_time = 16'd3000;
         lcdws_pkg::HOLD_T110:   seg.hold_time = 16'd110;
         lcdws_pkg::HOLD_T100:   seg.hold_time = 16'd100;
         lcdws_pkg::HOLD_T50:    seg.hold_time = 16'd50;
         default:                seg.hold_time = 16'd0;
      endcase
      seg.last = seg_last;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcdws_pkg::ST_IDLE: if (q_valid) state_in = lcdws_pkg::ST_RUN;
         lcdws_pkg::ST_RUN:  if (advance && seg_last) state_in = lcdws_pkg::ST_IDLE;
         default:            state_in = lcdws_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop = 1'b0;
      emit  = 1'b0;
      unique case (state_ff)
         lcdws_pkg::ST_IDLE: q_pop = q_valid;
         lcdws_pkg::ST_RUN:  emit  = advance;
         default: begin
            q_pop = 1'b0;
            emit  = 1'b0;
         end
      endcase
   end

   always_comb begin
      job_in       = q_pop ? q_job : job_ff;
      idx_in       = q_pop ? 5'd0 : (emit ? idx_ff + 5'd1 : idx_ff);
      rsp_in       = emit ? seg : rsp_ff;
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcdws_pkg::ST_IDLE;
         idx_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcdws_pkg::ST_RUN |-> idx_ff < seg_total)
      else $error("segment index past end of job");

   a_job_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcdws_pkg::ST_RUN && advance && seg_last
      |=> state_ff == lcdws_pkg::ST_IDLE && rsp_valid_ff && rsp_ff.last)
      else $error("final beat not flagged");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.accepted |-> rsp_ff.last && rsp_ff.hold_time == 16'd0)
      else $error("rejected request beat malformed");

   a_strobe_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.enable |-> !rsp_ff.last)
      else $error("job ended with enable high");

endmodule

`default_nettype wire

/* hdl/lcd_4bit_write_sequencer.sv */
// lcd_4bit_write_sequencer: top level, timing registers and the
// decode / queue / sequencer chain; depends on lcdws_pkg and the lcdws_* modules
//
// Turns character-lcd requests (init, character, clear, home, shifts,
// display mode, cursor position) into pin segments for a 4-bit bus: each
// rsp beat gives rs, e, d[7:4] levels and a hold time in delay ticks, with
// last set on the request's final beat. Requests are decoded as they arrive
// and held in a QUEUE_DEPTH-entry job queue, so req_ready stays high and a
// new request can be taken every cycle while the queue has room, even while
// a finished beat waits on rsp_ready. The sequencer emits one beat per cycle
// when the result side keeps up, and picks up each job from the queue in its
// idle state before it walks the job's segments. That walk of the sequencer,
// with the pickup of each job, sets the sustained rate. A bad display mode
// or an unknown command gives one beat with accepted low, last high and
// everything else zero. csr_index 0 is the enable pulse time (reset 5), 1
// the settle time after enable falls (reset 100); write them only while the
// block is idle.
`default_nettype none

module lcd_4bit_write_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire lcdws_pkg::req_type req_data,
   // segment channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lcdws_pkg::rsp_type      rsp_data,
   // timing registers
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_wdata
);

   // timing registers
   logic [15:0] pulse_time_ff, pulse_time_in;
   logic [15:0] settle_time_ff, settle_time_in;

   // front to queue
   logic               q_full;
   logic               q_push;
   lcdws_pkg::job_type push_job;

   // queue to back
   logic               q_pop;
   logic               q_valid;
   lcdws_pkg::job_type pop_job;

   always_comb begin
      pulse_time_in  = pulse_time_ff;
      settle_time_in = settle_time_ff;
      if (csr_we) begin
         case (csr_index)
            lcdws_pkg::CSR_PULSE:  pulse_time_in  = csr_wdata;
            lcdws_pkg::CSR_SETTLE: settle_time_in = csr_wdata;
            default: begin
               pulse_time_in  = pulse_time_ff;
               settle_time_in = settle_time_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_time_ff  <= lcdws_pkg::PULSE_RESET;
         settle_time_ff <= lcdws_pkg::SETTLE_RESET;
      end else begin
         pulse_time_ff  <= pulse_time_in;
         settle_time_ff <= settle_time_in;
      end
   end

   // decode each request into a job
   lcdws_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // decouples intake from the slow segment walk
   lcdws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (pop_job)
   );

   // one segment beat per cycle into the output register unless rsp_ready stalls it
   lcdws_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pulse_time  (pulse_time_ff),
      .settle_time (settle_time_ff),
      .q_valid     (q_valid),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
